### hw/rtl/group_pausable_clock_table_top_macros.svh
// assertion macros for the pausable clock table checker
// clk and rst_n are expected in the scope of each use
`ifndef GROUP_PAUSABLE_CLOCK_TABLE_TOP_MACROS_SVH
`define GROUP_PAUSABLE_CLOCK_TABLE_TOP_MACROS_SVH

// consequent in the same cycle
`define GPCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define GPCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/gpct_pkg.sv
`timescale 1ns / 1ps
package gpct_pkg;

  localparam int TIME_BITS = 63;
  localparam int KEY_FIELD_BITS = 64;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_PAUSE  = 2'd1;
  localparam logic [1:0] OP_RESUME = 2'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic [KEY_FIELD_BITS-1:0] group_key;
    logic [TIME_BITS-1:0]      now_time;
  } in_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] adj_time;
    logic                 ok;
    logic                 table_full;
  } out_item_t;

  // one memory word per entry
  typedef struct packed {
    logic [TIME_BITS-1:0] pause_time;
    logic [TIME_BITS-1:0] gap;
  } mem_word_t;

endpackage

### hw/rtl/gpct_match.sv
`timescale 1ns / 1ps
module gpct_match #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64,
  parameter int SW       = 4
) (
  input  logic [KEY_BITS-1:0] key,
  input  logic [KEY_BITS-1:0] keys [ENTRIES],
  input  logic [ENTRIES-1:0]  valid,
  output logic                hit,
  output logic [SW-1:0]       hit_idx,
  output logic                free_avail,
  output logic [SW-1:0]       free_idx
);

  // lowest matching slot and lowest free slot
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_avail = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == key) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
      if (!valid[i]) begin
        free_avail = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

endmodule

### hw/rtl/group_pausable_clock_table_top.sv
`timescale 1ns / 1ps
// pausable group clock table: one beat in, one beat out per request
// result: the request and its time memory word are registered on acceptance;
//   the word is modified, written back and the result beat registered once the
//   output register is free or being emptied; only then is a new request taken
// reset: entry valid and paused flags clear at once; no clearing pass,
//   memory contents and keys are left as they are
module group_pausable_clock_table_top #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gpct_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gpct_pkg::out_item_t out_data
);
  import gpct_pkg::*;

  // slot index width, at least one bit
  localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // sequencer codes
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;

  // key store and per-entry flags live in flip-flops for the parallel match
  logic [KEY_BITS-1:0] keys_r [ENTRIES];
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [ENTRIES-1:0]  paused_r, paused_nxt;

  // pause time and gap live in a synchronous memory
  mem_word_t mem [ENTRIES];
  mem_word_t rd_data_r;
  logic      mem_we;
  logic [SW-1:0] mem_addr;
  mem_word_t mem_wdata;

  // request captured at acceptance, with its lookup result
  logic [1:0]           kind_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [TIME_BITS-1:0] now_r;
  logic                 hit_r;
  logic [SW-1:0]        hit_idx_r;
  logic                 free_avail_r;
  logic [SW-1:0]        free_idx_r;

  logic                 out_valid_r;
  out_item_t            out_data_r;
  out_item_t            res;

  logic                 hit;
  logic [SW-1:0]        hit_idx;
  logic                 free_avail;
  logic [SW-1:0]        free_idx;
  logic [KEY_BITS-1:0]  in_key;

  logic in_acc;
  logic go;
  logic alloc;

  assign in_key   = in_data.group_key[KEY_BITS-1:0];
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // finish only once the output register is free or being emptied
  assign go       = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gpct_match #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS),
    .SW       (SW)
  ) u_match (
    .key        (in_key),
    .keys       (keys_r),
    .valid      (valid_r),
    .hit        (hit),
    .hit_idx    (hit_idx),
    .free_avail (free_avail),
    .free_idx   (free_idx)
  );

  // modify stage: works on the registered memory word
  always_comb begin
    res        = '0;
    mem_we     = 1'b0;
    mem_addr   = hit_idx_r;
    mem_wdata  = rd_data_r;
    valid_nxt  = valid_r;
    paused_nxt = paused_r;
    alloc      = 1'b0;
    case (kind_r)
      OP_READ: begin
        res.ok       = 1'b1;
        res.adj_time = now_r;
        if (key_r != '0 && hit_r) begin
          // frozen at the pause time while paused
          res.adj_time = (paused_r[hit_idx_r] ? rd_data_r.pause_time : now_r)
                         - rd_data_r.gap;
        end
      end
      OP_PAUSE: begin
        if (key_r != '0) begin
          if (hit_r) begin
            if (!paused_r[hit_idx_r]) begin
              mem_we                = 1'b1;
              mem_wdata.pause_time  = now_r;
              paused_nxt[hit_idx_r] = 1'b1;
              res.ok                = 1'b1;
            end
          end else if (free_avail_r) begin
            // fresh entry starts with no gap
            alloc                  = 1'b1;
            mem_we                 = 1'b1;
            mem_addr               = free_idx_r;
            mem_wdata.pause_time   = now_r;
            mem_wdata.gap          = '0;
            valid_nxt[free_idx_r]  = 1'b1;
            paused_nxt[free_idx_r] = 1'b1;
            res.ok                 = 1'b1;
          end else begin
            res.table_full = 1'b1;
          end
        end
      end
      OP_RESUME: begin
        if (key_r != '0 && hit_r && paused_r[hit_idx_r]) begin
          mem_we                = 1'b1;
          mem_wdata.gap         = rd_data_r.gap + (now_r - rd_data_r.pause_time);
          paused_nxt[hit_idx_r] = 1'b0;
          res.ok                = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (go) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      paused_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        valid_r     <= valid_nxt;
        paused_r    <= paused_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r       <= in_data.kind;
      key_r        <= in_key;
      now_r        <= in_data.now_time;
      hit_r        <= hit;
      hit_idx_r    <= hit_idx;
      free_avail_r <= free_avail;
      free_idx_r   <= free_idx;
    end
    if (go) begin
      out_data_r <= res;
    end
    if (go && alloc) begin
      keys_r[free_idx_r] <= key_r;
    end
  end

  // time memory: read on acceptance, written back in the modify cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= mem[hit_idx];
    end
    if (go && mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

endmodule

### hw/rtl/gpct_checker.sv
`timescale 1ns / 1ps
`include "group_pausable_clock_table_top_macros.svh"
module gpct_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input gpct_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input gpct_pkg::out_item_t out_data
);
  import gpct_pkg::*;

  // a stalled result beat holds
  `GPCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")

  // one request at a time: busy right after an accepted beat
  `GPCT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted a beat while busy")

  // a full table means a failed pause
  `GPCT_ASSERT_NOW(a_full_fails, out_valid && out_data.table_full, !out_data.ok, "table_full with ok set")

  // a table-full result carries no time
  `GPCT_ASSERT_NOW(a_full_no_time, out_valid && out_data.table_full, out_data.adj_time == '0, "table_full with time")

endmodule

bind group_pausable_clock_table_top gpct_checker u_gpct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
